// ----- design/rcf_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the command framer.
// No dependencies; every other design file depends on this package.
package rcf_pkg;

	localparam int ARG_LEN_LIMIT = 8192;
	localparam int ARG_SLOTS     = 32;
	localparam int NUM_W         = 14;
	localparam int LEN_W         = 13;
	localparam int IDX_W         = 5;
	localparam int CNT_W         = 6;

	localparam logic [NUM_W-1:0] NUM_SAT   = NUM_W'(ARG_LEN_LIMIT + 64);
	localparam logic [NUM_W-1:0] LEN_LIMIT = NUM_W'(ARG_LEN_LIMIT);
	localparam logic [CNT_W-1:0] SLOTS     = CNT_W'(ARG_SLOTS);

	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	typedef logic [7:0]       byte_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [1:0] {
		KIND_DATA     = 2'd0,
		KIND_EMPTY    = 2'd1,
		KIND_COMPLETE = 2'd2,
		KIND_ERROR    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ERR_BAD_START      = 2'd0,
		ERR_BAD_COUNT      = 2'd1,
		ERR_MISSING_DOLLAR = 2'd2,
		ERR_BAD_LENGTH     = 2'd3
	} err_t;

	typedef enum logic [10:0] {
		PH_IDLE      = 11'b000_0000_0001,
		PH_CNT_START = 11'b000_0000_0010,
		PH_CNT_BODY  = 11'b000_0000_0100,
		PH_CNT_CR    = 11'b000_0000_1000,
		PH_DOLLAR    = 11'b000_0001_0000,
		PH_LEN_START = 11'b000_0010_0000,
		PH_LEN_BODY  = 11'b000_0100_0000,
		PH_LEN_CR    = 11'b000_1000_0000,
		PH_DATA      = 11'b001_0000_0000,
		PH_TRAIL1    = 11'b010_0000_0000,
		PH_TRAIL2    = 11'b100_0000_0000
	} phase_t;

	typedef struct packed {
		kind_t            result_kind;
		byte_t            data_byte;
		logic [IDX_W-1:0] arg_index;
		logic             arg_last_byte;
		cnt_t             arg_total;
		err_t             error_code;
	} result_t;

endpackage

// ----- design/rcf_byte_if.sv -----
`timescale 1ns / 1ps
// Byte stream channel into the framer: valid/ready plus one raw byte.
// Depends on rcf_pkg.
interface rcf_byte_if;
	logic            valid;
	logic            ready;
	rcf_pkg::byte_t  in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

// ----- design/rcf_result_if.sv -----
`timescale 1ns / 1ps
// Result channel out of the framer: valid/ready plus the result fields.
// Depends on rcf_pkg.
interface rcf_result_if;
	logic                          valid;
	logic                          ready;
	rcf_pkg::kind_t                result_kind;
	rcf_pkg::byte_t                data_byte;
	logic [rcf_pkg::IDX_W-1:0]     arg_index;
	logic                          arg_last_byte;
	rcf_pkg::cnt_t                 arg_total;
	rcf_pkg::err_t                 error_code;

	modport source (output valid, output result_kind, output data_byte, output arg_index,
		output arg_last_byte, output arg_total, output error_code, input ready);
	modport sink   (input valid, input result_kind, input data_byte, input arg_index,
		input arg_last_byte, input arg_total, input error_code, output ready);
endinterface

// ----- design/rcf_cfg_if.sv -----
`timescale 1ns / 1ps
// Configuration write channel: valid/ready plus the argument limit.
// Depends on rcf_pkg.
interface rcf_cfg_if;
	logic           valid;
	logic           ready;
	rcf_pkg::cnt_t  max_arguments;

	modport source (output valid, output max_arguments, input ready);
	modport sink   (input valid, input max_arguments, output ready);
endinterface

// ----- design/resp_command_framer.sv -----
`timescale 1ns / 1ps
// Command framer top level: input byte register, parser, result register.
// Path: an accepted byte is held in the input register, then the parser's result for it
// is loaded into the result register, from which the result channel is driven.
// Throughput: one byte per cycle; a stalled result holds the input register.
// Reset: arst_n clears the pipeline valids, the parser state (idle, awaiting '*')
// and sets the argument limit to 32. Depends on rcf_pkg, the interfaces and rcf_parser.
module resp_command_framer (
	input  logic            clk,
	input  logic            arst_n,
	rcf_byte_if.sink        stream,
	rcf_result_if.source    result,
	rcf_cfg_if.sink         cfg
);
	import rcf_pkg::*;

	// Argument limit register; write it only while no byte is in flight.
	cnt_t     max_args_q;

	// Input register stage.
	logic     valid_s1;
	byte_t    byte_s1;

	// Result register.
	logic     out_valid_q;
	result_t  out_q;

	logic     advance;
	logic     res_valid;
	result_t  res;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_args_q <= SLOTS;
		end else if (cfg.valid) begin
			max_args_q <= cfg.max_arguments;
		end
	end

	// Advance the held byte through the parser whenever the result register
	// is free or is being drained in this cycle.
	assign advance      = valid_s1 && (!out_valid_q || result.ready);
	assign stream.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	// Payload register: no reset needed.
	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			byte_s1 <= stream.in_byte;
		end
	end

	rcf_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.in_byte       (byte_s1),
		.max_arguments (max_args_q),
		.res_valid     (res_valid),
		.res           (res)
	);

	// Load the result register on every advance (a byte that yields no
	// result leaves it empty); otherwise drop the item once it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.result_kind   = out_q.result_kind;
	assign result.data_byte     = out_q.data_byte;
	assign result.arg_index     = out_q.arg_index;
	assign result.arg_last_byte = out_q.arg_last_byte;
	assign result.arg_total     = out_q.arg_total;
	assign result.error_code    = out_q.error_code;

endmodule

// ----- design/rcf_parser.sv -----
`timescale 1ns / 1ps
// Frame parser state and its one-byte update; produces at most one result per step.
// Depends on rcf_pkg.
module rcf_parser (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  rcf_pkg::byte_t         in_byte,
	input  rcf_pkg::cnt_t          max_arguments,
	output logic                   res_valid,
	output rcf_pkg::result_t       res
);
	import rcf_pkg::*;

	phase_t             phase_q, phase_d;
	logic [NUM_W-1:0]   num_q, num_d;
	logic               neg_q, neg_d;
	logic               ended_q, ended_d;
	cnt_t               held_q, held_d;
	logic [IDX_W-1:0]   cur_q, cur_d;
	logic [LEN_W-1:0]   left_q, left_d;

	logic               is_start, is_cr, is_digit, sat, line_done, to_cr;
	logic [NUM_W+2:0]   acc;
	logic [NUM_W-1:0]   ln_num;
	logic               ln_neg, ln_end;
	cnt_t               lim, nxt_arg;
	logic [LEN_W-1:0]   left_dec;

	// Number-line byte: sign, digit accumulation with saturation, CR/LF tracking.
	always_comb begin
		is_start  = (phase_q == PH_CNT_START) || (phase_q == PH_LEN_START);
		is_cr     = (phase_q == PH_CNT_CR) || (phase_q == PH_LEN_CR);
		is_digit  = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
		acc       = ({3'b000, num_q} * (NUM_W+3)'(10)) + (NUM_W+3)'(in_byte - CH_ZERO);
		sat       = acc > (NUM_W+3)'(NUM_SAT);
		line_done = is_cr && (in_byte == CH_LF);
		to_cr     = 1'b0;
		ln_num    = num_q;
		ln_neg    = neg_q;
		ln_end    = ended_q | is_cr;
		if (in_byte == CH_CR) begin
			ln_end = 1'b1;
			to_cr  = 1'b1;
		end else if (is_start && (in_byte == CH_MINUS)) begin
			ln_neg = 1'b1;
		end else if (!ln_end && is_digit) begin
			ln_num = sat ? NUM_SAT : acc[NUM_W-1:0];
		end else begin
			ln_end = 1'b1;
		end
	end

	always_comb begin
		lim      = (max_arguments >= SLOTS) ? SLOTS : max_arguments;
		nxt_arg  = {1'b0, cur_q} + cnt_t'(1);
		left_dec = (left_q != '0) ? left_q - LEN_W'(1) : left_q;

		phase_d   = phase_q;
		num_d     = num_q;
		neg_d     = neg_q;
		ended_d   = ended_q;
		held_d    = held_q;
		cur_d     = cur_q;
		left_d    = left_q;
		res_valid = 1'b0;
		res       = '0;

		case (phase_q)
			PH_IDLE: begin
				if (in_byte == CH_STAR) begin
					num_d   = '0;
					neg_d   = 1'b0;
					ended_d = 1'b0;
					phase_d = PH_CNT_START;
				end else begin
					res_valid       = 1'b1;
					res.result_kind = KIND_ERROR;
					res.error_code  = ERR_BAD_START;
				end
			end
			PH_CNT_START, PH_CNT_BODY, PH_CNT_CR: begin
				if (!line_done) begin
					num_d   = ln_num;
					neg_d   = ln_neg;
					ended_d = ln_end;
					phase_d = to_cr ? PH_CNT_CR : PH_CNT_BODY;
				end else if ((num_q == '0) || neg_q || (num_q > NUM_W'(lim))) begin
					phase_d         = PH_IDLE;
					res_valid       = 1'b1;
					res.result_kind = KIND_ERROR;
					res.error_code  = ERR_BAD_COUNT;
				end else begin
					held_d  = num_q[CNT_W-1:0];
					cur_d   = '0;
					phase_d = PH_DOLLAR;
				end
			end
			PH_DOLLAR: begin
				if (in_byte == CH_DOLLAR) begin
					num_d   = '0;
					neg_d   = 1'b0;
					ended_d = 1'b0;
					phase_d = PH_LEN_START;
				end else begin
					phase_d         = PH_IDLE;
					res_valid       = 1'b1;
					res.result_kind = KIND_ERROR;
					res.error_code  = ERR_MISSING_DOLLAR;
				end
			end
			PH_LEN_START, PH_LEN_BODY, PH_LEN_CR: begin
				if (!line_done) begin
					num_d   = ln_num;
					neg_d   = ln_neg;
					ended_d = ln_end;
					phase_d = to_cr ? PH_LEN_CR : PH_LEN_BODY;
				end else if ((neg_q && (num_q != '0)) || (num_q >= LEN_LIMIT)) begin
					phase_d         = PH_IDLE;
					res_valid       = 1'b1;
					res.result_kind = KIND_ERROR;
					res.error_code  = ERR_BAD_LENGTH;
				end else if (num_q == '0) begin
					phase_d         = PH_TRAIL1;
					res_valid       = 1'b1;
					res.result_kind = KIND_EMPTY;
					res.arg_index   = cur_q;
				end else begin
					left_d  = num_q[LEN_W-1:0];
					phase_d = PH_DATA;
				end
			end
			PH_DATA: begin
				res_valid         = 1'b1;
				res.result_kind   = KIND_DATA;
				res.data_byte     = in_byte;
				res.arg_index     = cur_q;
				res.arg_last_byte = (left_q <= LEN_W'(1));
				left_d            = left_dec;
				if (left_dec == '0) begin
					phase_d = PH_TRAIL1;
				end
			end
			PH_TRAIL1: begin
				phase_d = PH_TRAIL2;
			end
			PH_TRAIL2: begin
				if (nxt_arg >= held_q) begin
					phase_d         = PH_IDLE;
					res_valid       = 1'b1;
					res.result_kind = KIND_COMPLETE;
					res.arg_total   = held_q;
				end else begin
					cur_d   = nxt_arg[IDX_W-1:0];
					phase_d = PH_DOLLAR;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			num_q   <= '0;
			neg_q   <= 1'b0;
			ended_q <= 1'b0;
			held_q  <= '0;
			cur_q   <= '0;
			left_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			num_q   <= num_d;
			neg_q   <= neg_d;
			ended_q <= ended_d;
			held_q  <= held_d;
			cur_q   <= cur_d;
			left_q  <= left_d;
		end
	end

endmodule

// ----- tb/resp_command_framer_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of resp_command_framer: byte stream in, framed results out.
// Uses rcf_pkg and the rcf_byte_if, rcf_result_if and rcf_cfg_if interfaces.
module resp_command_framer_tb;
	import rcf_pkg::*;

	localparam int CLK_HALF    = 4;
	localparam int RESET_CYC   = 4;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYC   = 8;
	localparam int SHOW_MAX    = 10;
	localparam int LONG_ARG    = 200;

	logic clk = 1'b0;
	logic arst_n;

	rcf_byte_if   stream_if ();
	rcf_result_if result_if ();
	rcf_cfg_if    cfg_if ();

	resp_command_framer i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_if),
		.result (result_if),
		.cfg    (cfg_if)
	);

	always #CLK_HALF clk = ~clk;

	// Stimulus backlog, expected results and run statistics.
	byte_t   pending_bytes[$];
	result_t expected_results[$];
	int      bytes_queued;
	int      bytes_taken;
	int      limit_writes;
	int      mismatches;
	int      kind_seen[4];
	int      src_idle_pct;
	int      sink_stall_pct;
	int      quiet_cycles;

	// Own copy of the parser state and of the argument limit.
	cnt_t             limit_reg;
	phase_t           ph;
	logic [NUM_W-1:0] num_val;
	bit               num_neg;
	bit               num_done;
	cnt_t             frame_args;
	int               args_done;
	logic [LEN_W-1:0] owed;

	// ------------------------------------------------------------------
	// Frame parser prediction
	// ------------------------------------------------------------------
	task automatic clear_number();
		num_val  = '0;
		num_neg  = 1'b0;
		num_done = 1'b0;
	endtask

	// Advance one byte of a count or length line; flag the LF that ends it.
	task automatic take_number_byte(input byte_t b, input phase_t start_ph,
		input phase_t body_ph, input phase_t cr_ph, output bit line_done);
		int acc;
		line_done = 1'b0;
		if (ph == cr_ph && b == CH_LF) begin
			line_done = 1'b1;
		end else begin
			// a CR not followed by LF is just another non-digit
			if (ph == cr_ph)
				num_done = 1'b1;
			if (b == CH_CR) begin
				num_done = 1'b1;
				ph = cr_ph;
			end else begin
				if (ph == start_ph && b == CH_MINUS) begin
					num_neg = 1'b1;
				end else if (!num_done && b >= CH_ZERO && b <= CH_NINE) begin
					acc = num_val * 10 + (b - CH_ZERO);
					// hold at the saturation value so oversize numbers stay rejected
					num_val = (acc > NUM_SAT) ? NUM_SAT : NUM_W'(acc);
				end else begin
					num_done = 1'b1;
				end
				ph = body_ph;
			end
		end
	endtask

	task automatic parse_byte(input byte_t b, output bit produced, output result_t r);
		bit line_done;
		int lim;
		produced = 1'b0;
		r        = '0;
		lim      = (limit_reg < SLOTS) ? limit_reg : SLOTS;
		case (ph)
			PH_IDLE: begin
				if (b == CH_STAR) begin
					clear_number();
					ph = PH_CNT_START;
				end else begin
					produced     = 1'b1;
					r.result_kind = KIND_ERROR;
					r.error_code  = ERR_BAD_START;
				end
			end
			PH_CNT_START, PH_CNT_BODY, PH_CNT_CR: begin
				take_number_byte(b, PH_CNT_START, PH_CNT_BODY, PH_CNT_CR, line_done);
				if (line_done) begin
					if (num_val == 0 || num_neg || num_val > lim) begin
						ph            = PH_IDLE;
						produced      = 1'b1;
						r.result_kind = KIND_ERROR;
						r.error_code  = ERR_BAD_COUNT;
					end else begin
						frame_args = CNT_W'(num_val);
						args_done  = 0;
						ph         = PH_DOLLAR;
					end
				end
			end
			PH_DOLLAR: begin
				if (b == CH_DOLLAR) begin
					clear_number();
					ph = PH_LEN_START;
				end else begin
					ph            = PH_IDLE;
					produced      = 1'b1;
					r.result_kind = KIND_ERROR;
					r.error_code  = ERR_MISSING_DOLLAR;
				end
			end
			PH_LEN_START, PH_LEN_BODY, PH_LEN_CR: begin
				take_number_byte(b, PH_LEN_START, PH_LEN_BODY, PH_LEN_CR, line_done);
				if (line_done) begin
					// negative zero passes as an empty argument
					if ((num_neg && num_val != 0) || num_val >= LEN_LIMIT) begin
						ph            = PH_IDLE;
						produced      = 1'b1;
						r.result_kind = KIND_ERROR;
						r.error_code  = ERR_BAD_LENGTH;
					end else if (num_val == 0) begin
						ph            = PH_TRAIL1;
						produced      = 1'b1;
						r.result_kind = KIND_EMPTY;
						r.arg_index   = IDX_W'(args_done);
					end else begin
						owed = LEN_W'(num_val);
						ph   = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				produced        = 1'b1;
				r.result_kind   = KIND_DATA;
				r.data_byte     = b;
				r.arg_index     = IDX_W'(args_done);
				r.arg_last_byte = (owed <= 1);
				if (owed > 0)
					owed = owed - 1'b1;
				if (owed == 0)
					ph = PH_TRAIL1;
			end
			PH_TRAIL1: begin
				ph = PH_TRAIL2;
			end
			PH_TRAIL2: begin
				// completion is reported on the second trailer of the last argument
				args_done++;
				if (args_done >= frame_args) begin
					ph            = PH_IDLE;
					produced      = 1'b1;
					r.result_kind = KIND_COMPLETE;
					r.arg_total   = frame_args;
				end else begin
					ph = PH_DOLLAR;
				end
			end
			default: begin
				ph = PH_IDLE;
			end
		endcase
	endtask

	function automatic string show_result(result_t r);
		return $sformatf("kind=%0d data=%02h idx=%0d last=%0d total=%0d err=%0d",
			r.result_kind, r.data_byte, r.arg_index, r.arg_last_byte, r.arg_total,
			r.error_code);
	endfunction

	// ------------------------------------------------------------------
	// Stream driver: present the next pending byte once the last one is taken
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_if.valid   <= 1'b0;
			stream_if.in_byte <= '0;
		end else if (!stream_if.valid || stream_if.ready) begin
			if (pending_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				stream_if.valid   <= 1'b1;
				stream_if.in_byte <= pending_bytes.pop_front();
			end else begin
				stream_if.valid <= 1'b0;
			end
		end
	end

	// Predict on every accepted byte.
	always @(posedge clk) begin
		bit      produced;
		result_t r;
		if (arst_n && stream_if.valid && stream_if.ready) begin
			parse_byte(stream_if.in_byte, produced, r);
			if (produced)
				expected_results.push_back(r);
			bytes_taken++;
		end
	end

	// ------------------------------------------------------------------
	// Result monitor: check each accepted result, then pick the next ready
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			result_if.ready <= 1'b0;
		end else begin
			if (result_if.valid && result_if.ready) begin
				got.result_kind   = result_if.result_kind;
				got.data_byte     = result_if.data_byte;
				got.arg_index     = result_if.arg_index;
				got.arg_last_byte = result_if.arg_last_byte;
				got.arg_total     = result_if.arg_total;
				got.error_code    = result_if.error_code;
				kind_seen[got.result_kind]++;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= SHOW_MAX)
						$display("%0t: result with nothing expected: %s", $realtime,
							show_result(got));
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= SHOW_MAX)
							$display("%0t: mismatch\n  expected %s\n  actual   %s",
								$realtime, show_result(want), show_result(got));
					end
				end
			end
			result_if.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Watchdog: stop a run in which nothing moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((stream_if.valid && stream_if.ready) || (result_if.valid && result_if.ready)
				|| (cfg_if.valid && cfg_if.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $realtime, STALL_LIMIT);
				$display("resp_command_framer_tb: FAIL");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus construction
	// ------------------------------------------------------------------
	task automatic push_byte(input byte_t b);
		pending_bytes.push_back(b);
		bytes_queued++;
	endtask

	task automatic push_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			push_byte(byte_t'(s[i]));
	endtask

	// Emit one number line, sometimes with leading zeros, junk after the digits,
	// a stray CR or a doubled CR before the closing CR LF.
	task automatic put_number(input int value, input bit neg);
		byte_t b;
		if (neg)
			push_byte(CH_MINUS);
		if ($urandom_range(9) == 0)
			repeat ($urandom_range(3, 1)) push_byte(CH_ZERO);
		push_text($sformatf("%0d", value));
		if ($urandom_range(7) == 0) begin
			// first junk byte must end the digits
			b = byte_t'($urandom_range(255));
			if ((b >= CH_ZERO && b <= CH_NINE) || b == CH_CR)
				b = 8'h20;
			push_byte(b);
			repeat ($urandom_range(3)) begin
				b = byte_t'($urandom_range(255));
				push_byte(b);
				// never let junk close the line early
				if (b == CH_CR)
					push_byte(8'h5A);
			end
		end
		if ($urandom_range(19) == 0)
			push_byte(CH_CR);
		push_byte(CH_CR);
		push_byte(CH_LF);
	endtask

	// Build one frame; forced_len >= 0 fixes the first argument length.
	task automatic make_frame(input int forced_len);
		int    lim;
		int    n_args;
		int    len;
		int    k;
		int    pick;
		bit    cut_short;
		byte_t b;
		lim = (limit_reg < SLOTS) ? limit_reg : SLOTS;
		// stray bytes outside any frame
		if (forced_len < 0 && $urandom_range(99) < 5) begin
			repeat ($urandom_range(4, 1)) push_byte(byte_t'($urandom_range(255)));
			return;
		end
		push_byte(CH_STAR);
		if (lim == 0 || (forced_len < 0 && $urandom_range(9) == 0)) begin
			// count that must be rejected; drop the rest of the frame
			case ($urandom_range(4))
				0: put_number(0, 1'($urandom_range(1)));
				1: put_number(lim + 1, 1'b0);
				2: put_number($urandom_range(9, 1), 1'b1);
				3: put_number($urandom_range(32'h7FFF_FFFF, 100000), 1'b0);
				default: begin
					push_byte(CH_CR);
					push_byte(CH_LF);
				end
			endcase
			return;
		end
		if ($urandom_range(3) == 0)
			n_args = $urandom_range(lim, 1);
		else
			n_args = $urandom_range((lim < 3) ? lim : 3, 1);
		put_number(n_args, 1'b0);
		cut_short = ($urandom_range(49) == 0);
		for (k = 0; k < n_args; k++) begin
			if ($urandom_range(49) == 0) begin
				b = byte_t'($urandom_range(255));
				push_byte((b == CH_DOLLAR) ? CH_STAR : b);
				return;
			end
			push_byte(CH_DOLLAR);
			pick = $urandom_range(99);
			if (k == 0 && forced_len >= 0) begin
				len = forced_len;
				put_number(len, 1'b0);
			end else if (pick < 10) begin
				len = 0;
				put_number(0, 1'($urandom_range(1)));
			end else if (pick < 12) begin
				// a line with no digits reads as zero
				len = 0;
				push_byte(CH_CR);
				push_byte(CH_LF);
			end else if (pick < 82) begin
				len = $urandom_range(6, 1);
				put_number(len, 1'b0);
			end else if (pick < 94) begin
				len = $urandom_range(40, 7);
				put_number(len, 1'b0);
			end else begin
				case ($urandom_range(3))
					0: put_number($urandom_range(99, 1), 1'b1);
					1: put_number(ARG_LEN_LIMIT, 1'b0);
					2: put_number($urandom_range(9999, ARG_LEN_LIMIT + 1), 1'b0);
					default: put_number($urandom_range(32'h7FFF_FFFF, 100000), 1'b0);
				endcase
				return;
			end
			repeat (len) begin
				push_byte(byte_t'($urandom_range(255)));
				if (cut_short && $urandom_range(3) == 0)
					return;
			end
			// trailers go unchecked: mostly CR LF, sometimes anything
			if ($urandom_range(9) < 7) begin
				push_byte(CH_CR);
				push_byte(CH_LF);
			end else begin
				push_byte(byte_t'($urandom_range(255)));
				push_byte(byte_t'($urandom_range(255)));
			end
		end
	endtask

	// Hold until every byte is taken and every expected result has arrived,
	// then let the pipeline run dry.
	task automatic settle();
		while (pending_bytes.size() != 0 || stream_if.valid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic write_limit(input cnt_t v);
		@(posedge clk);
		cfg_if.valid         <= 1'b1;
		cfg_if.max_arguments <= v;
		do
			@(posedge clk);
		while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		limit_reg = v;
		limit_writes++;
	endtask

	// One phase: optional limit write, idling mix, random frames with a
	// full pause of the sender halfway through.
	task automatic run_phase(input int new_limit, input int idle_pct, input int stall_pct,
		input int budget, input bit with_long_arg);
		int start;
		if (new_limit >= 0)
			write_limit(cnt_t'(new_limit));
		src_idle_pct   = idle_pct;
		sink_stall_pct = stall_pct;
		if (with_long_arg)
			make_frame(LONG_ARG);
		start = bytes_queued;
		while (bytes_queued - start < budget / 2)
			make_frame(-1);
		settle();
		while (bytes_queued - start < budget)
			make_frame(-1);
		settle();
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n               = 1'b0;
		stream_if.valid      = 1'b0;
		stream_if.in_byte    = '0;
		cfg_if.valid         = 1'b0;
		cfg_if.max_arguments = '0;
		result_if.ready      = 1'b0;
		src_idle_pct         = 0;
		sink_stall_pct       = 0;
		quiet_cycles         = 0;
		bytes_queued         = 0;
		bytes_taken          = 0;
		limit_writes         = 0;
		mismatches           = 0;
		kind_seen            = '{default: 0};
		limit_reg            = SLOTS;
		ph                   = PH_IDLE;
		clear_number();
		frame_args           = '0;
		args_done            = 0;
		owed                 = '0;
		repeat (RESET_CYC) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: bad starts at both byte extremes, a count above the limit,
		// a negative-zero empty argument followed by a missing dollar, and a
		// one-byte argument that completes its frame.
		push_byte(8'hFF);
		push_byte(8'h00);
		push_text("*33\r\n");
		push_text("*2\r\n$-0\r\n\r\nx");
		push_text("*1\r\n$1\r\n");
		push_byte(8'hFF);
		push_text("\r\n");

		run_phase(-1, 0, 0, 250, 1'b0);
		run_phase(1, 64, 0, 300, 1'b0);
		run_phase(63, 0, 64, 300, 1'b0);
		run_phase(0, 11, 11, 100, 1'b0);
		run_phase(32, 0, 0, 300, 1'b1);
		run_phase($urandom_range(31, 2), 11, 11, 300, 1'b0);

		$display("run covered %0d stream bytes over %0d argument-limit settings",
			bytes_taken, limit_writes + 1);
		$display("results seen: %0d data, %0d empty, %0d complete, %0d error",
			kind_seen[KIND_DATA], kind_seen[KIND_EMPTY], kind_seen[KIND_COMPLETE],
			kind_seen[KIND_ERROR]);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("resp_command_framer_tb: PASS");
		end else begin
			$display("resp_command_framer_tb: FAIL");
		end
		$finish;
	end

endmodule
